// ===== src/sitda_pkg.sv =====
package sitda_pkg;

  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int CHAR_W              = 7;
  localparam int COUNT_W             = 4;
  localparam int DIGIT_W             = 4;
  localparam int DABBLE_BITS         = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_COUNT,
    ST_SIGN,
    ST_DIGITS
  } back_state_t;

endpackage

// ===== src/sitda_if.sv =====
interface sitda_in_if import sitda_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
);
  logic                           valid;
  logic                           ready;
  logic signed [VALUE_WIDTH-1:0]  value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sitda_out_if import sitda_pkg::*;;
  logic               valid;
  logic               ready;
  logic [CHAR_W-1:0]  character;
  logic               last;
  logic [COUNT_W-1:0] char_count;

  modport source (output valid, output character, output last, output char_count, input ready);
  modport sink   (input valid, input character, input last, input char_count, output ready);
endinterface

// ===== src/signed_int_to_decimal_ascii.sv =====
// Prints a two's complement number as decimal ASCII, one character per output item, most
// significant first: a leading '-' for negative values, no leading zeros, zero as "0", and
// the most negative value in full. The final character has last set and carries the
// character count (low four bits); other characters carry a count of zero. A two-entry
// queue holds numbers ahead of the converter, so input is taken while output stalls.
// Each number passes through the double-dabble converter, which shifts four bits a cycle,
// then the emitter, which sends one character per cycle while the output is ready.
module signed_int_to_decimal_ascii import sitda_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic         clk,
  input  logic         rst,
  sitda_in_if.sink     number,
  sitda_out_if.source  text
);

  logic                   q_valid;
  logic                   q_neg;
  logic [VALUE_WIDTH-1:0] q_mag;
  logic                   q_pop;

  sitda_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .number  (number),
    .q_valid (q_valid),
    .q_neg   (q_neg),
    .q_mag   (q_mag),
    .q_pop   (q_pop)
  );

  sitda_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_neg   (q_neg),
    .q_mag   (q_mag),
    .q_pop   (q_pop),
    .text    (text)
  );

endmodule

// ===== src/sitda_front.sv =====
module sitda_front import sitda_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  sitda_in_if.sink               number,
  output logic                   q_valid,
  output logic                   q_neg,
  output logic [VALUE_WIDTH-1:0] q_mag,
  input  logic                   q_pop
);

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   neg;
  logic                   push;

  logic                   neg_q [2];
  logic [VALUE_WIDTH-1:0] mag_q [2];
  logic                   wr_ptr;
  logic                   rd_ptr;
  logic [1:0]             fill;

  // magnitude modulo 2^W: the most negative value maps onto itself
  assign raw  = number.value;
  assign neg  = raw[VALUE_WIDTH-1];
  assign mag  = neg ? (~raw + 1'b1) : raw;

  assign number.ready = (fill != 2'd2);
  assign push         = number.valid && number.ready;

  assign q_valid = (fill != 2'd0);
  assign q_neg   = neg_q[rd_ptr];
  assign q_mag   = mag_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      neg_q[wr_ptr] <= neg;
      mag_q[wr_ptr] <= mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

// ===== src/sitda_back.sv =====
module sitda_back import sitda_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  logic                   q_neg,
  input  logic [VALUE_WIDTH-1:0] q_mag,
  output logic                   q_pop,
  sitda_out_if.source            text
);

  // decimal digits of 2^W - 1, floor(W * log10(2)) + 1
  localparam int DigitCount = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int BCD_W      = DigitCount * DIGIT_W;
  localparam int CHUNKS     = (VALUE_WIDTH + DABBLE_BITS - 1) / DABBLE_BITS;
  localparam int PAD_W      = CHUNKS * DABBLE_BITS;
  localparam int STEP_W     = $clog2(CHUNKS);
  localparam int CNT_W      = $clog2(DigitCount + 1);
  localparam int POS_W      = $clog2(DigitCount);
  localparam int TOT_W      = (CNT_W + 1 > COUNT_W) ? CNT_W + 1 : COUNT_W;

  function automatic logic [BCD_W+PAD_W-1:0] dabble(input logic [BCD_W+PAD_W-1:0] x);
    logic [BCD_W+PAD_W-1:0] y;
    y = x;
    for (int k = 0; k < DABBLE_BITS; k++) begin
      for (int d = 0; d < DigitCount; d++) begin
        if (y[PAD_W + DIGIT_W*d +: DIGIT_W] >= 4'd5) begin
          y[PAD_W + DIGIT_W*d +: DIGIT_W] = y[PAD_W + DIGIT_W*d +: DIGIT_W] + 4'd3;
        end
      end
      y = y << 1;
    end
    return y;
  endfunction

  back_state_t            state, state_next;
  logic [PAD_W-1:0]       shreg, shreg_next;
  logic [BCD_W-1:0]       bcd, bcd_next;
  logic [STEP_W-1:0]      step, step_next;
  logic                   neg, neg_next;
  logic [POS_W-1:0]       pos, pos_next;
  logic [TOT_W-1:0]       total, total_next;

  logic                   out_valid;
  logic [CHAR_W-1:0]      out_char;
  logic                   out_last;
  logic [COUNT_W-1:0]     out_count;

  logic                   out_free;
  logic                   load;
  logic [CHAR_W-1:0]      load_char;
  logic                   load_last;
  logic [COUNT_W-1:0]     load_count;
  logic [CNT_W-1:0]       lead_count;
  logic [DIGIT_W-1:0]     digits [DigitCount];

  always_comb begin
    for (int d = 0; d < DigitCount; d++) begin
      digits[d] = bcd[DIGIT_W*d +: DIGIT_W];
    end
  end

  // count of digits up to the top non-zero digit; zero still prints one digit
  always_comb begin
    lead_count = CNT_W'(1);
    for (int d = 1; d < DigitCount; d++) begin
      if (digits[d] != '0) begin
        lead_count = CNT_W'(d + 1);
      end
    end
  end

  assign out_free = !out_valid || text.ready;

  always_comb begin
    state_next = state;
    shreg_next = shreg;
    bcd_next   = bcd;
    step_next  = step;
    neg_next   = neg;
    pos_next   = pos;
    total_next = total;
    q_pop      = 1'b0;
    load       = 1'b0;
    load_char  = CHAR_ZERO;
    load_last  = 1'b0;
    load_count = '0;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          neg_next   = q_neg;
          shreg_next = PAD_W'(q_mag);
          bcd_next   = '0;
          step_next  = '0;
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        {bcd_next, shreg_next} = dabble({bcd, shreg});
        step_next = step + 1'b1;
        if (step == STEP_W'(CHUNKS - 1)) begin
          state_next = ST_COUNT;
        end
      end
      ST_COUNT: begin
        pos_next   = POS_W'(lead_count - 1'b1);
        total_next = TOT_W'(lead_count) + TOT_W'(neg);
        state_next = neg ? ST_SIGN : ST_DIGITS;
      end
      ST_SIGN: begin
        if (out_free) begin
          load       = 1'b1;
          load_char  = CHAR_MINUS;
          state_next = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (out_free) begin
          load      = 1'b1;
          load_char = CHAR_ZERO + CHAR_W'(digits[pos]);
          if (pos == '0) begin
            load_last  = 1'b1;
            load_count = total[COUNT_W-1:0];
            state_next = ST_IDLE;
          end else begin
            pos_next = pos - 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    shreg <= shreg_next;
    bcd   <= bcd_next;
    step  <= step_next;
    neg   <= neg_next;
    pos   <= pos_next;
    total <= total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (text.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_char  <= load_char;
      out_last  <= load_last;
      out_count <= load_count;
    end
  end

  assign text.valid      = out_valid;
  assign text.character  = out_char;
  assign text.last       = out_last;
  assign text.char_count = out_count;

endmodule

// ===== tb/sitda_text_checker.sv =====
module sitda_text_checker import sitda_pkg::*; #(
  parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [CHAR_W-1:0]             out_character,
  input  logic                          out_last,
  input  logic [COUNT_W-1:0]            out_count,
  output int                            mismatches,
  output int                            pending,
  output int                            texts_checked,
  output int                            chars_checked
);

  localparam int MAX_DIGITS = 20;
  localparam int PRINT_CAP  = 40;

  typedef struct {
    logic [CHAR_W-1:0]             character;
    logic                          last;
    logic [COUNT_W-1:0]            char_count;
    logic signed [VALUE_WIDTH-1:0] number;
  } text_char_t;

  text_char_t expected_text [$];
  text_char_t want;

  initial begin
    mismatches    = 0;
    pending       = 0;
    texts_checked = 0;
    chars_checked = 0;
  end

  function automatic void spell_decimal(input logic signed [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH-1:0] mag;
    logic [DIGIT_W-1:0]     digits [0:MAX_DIGITS-1];
    logic                   neg;
    logic [COUNT_W-1:0]     total;
    text_char_t             c;
    int                     n;
    neg = v[VALUE_WIDTH-1];
    mag = v;
    if (neg) mag = ~mag + 1'b1;
    n = 0;
    do begin
      digits[n] = DIGIT_W'(mag % 10);
      mag       = mag / 10;
      n++;
    end while (mag != 0 && n < MAX_DIGITS);
    total    = COUNT_W'(n + int'(neg));
    c.number = v;
    if (neg) begin
      c.character  = CHAR_MINUS;
      c.last       = 1'b0;
      c.char_count = '0;
      expected_text.push_back(c);
    end
    for (int i = n; i > 0; i--) begin
      c.character  = CHAR_W'(CHAR_ZERO + digits[i-1]);
      c.last       = (i == 1);
      c.char_count = (i == 1) ? total : '0;
      expected_text.push_back(c);
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint exp_v,
                                 input logic signed [VALUE_WIDTH-1:0] number);
    if (mismatches < PRINT_CAP)
      $display("MISMATCH %s: got %0d, want %0d (number %0d)", what, got, exp_v, number);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        chars_checked++;
        if (out_last) texts_checked++;
        if (expected_text.size() == 0) begin
          report_mismatch("unexpected item, character", out_character, -1, '0);
        end else begin
          want = expected_text.pop_front();
          if (out_character !== want.character)
            report_mismatch("character", out_character, want.character, want.number);
          if (out_last !== want.last)
            report_mismatch("last", out_last, want.last, want.number);
          if (out_count !== want.char_count)
            report_mismatch("char_count", out_count, want.char_count, want.number);
        end
      end
      if (in_valid && in_ready) spell_decimal(in_value);
      pending = expected_text.size();
    end
  end

endmodule

// ===== tb/signed_int_to_decimal_ascii_tb.sv =====
module signed_int_to_decimal_ascii_tb import sitda_pkg::*;;

  localparam int VW           = 32;
  localparam int RANDOM_ITEMS = 280;
  localparam int CALM_ITEMS   = 60;
  localparam int LONG_HOLD    = 300;
  localparam int SETTLE       = 40;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst;
  int   cycle_count;
  int   numbers_sent;
  int   mismatches;
  int   pending;
  int   texts_checked;
  int   chars_checked;
  logic calm;
  logic long_hold_req;
  logic src_quiet;
  int   src_quiet_left;

  logic [VW-1:0] directed_values [$] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100, -32'sd100,
    32'd12345, 32'd999999999, 32'd1000000000, -32'sd1000000000, 32'd1234567890,
    -32'sd1234567890, 32'h7fff_ffff, 32'h8000_0001, 32'h8000_0000, 32'h5555_5555,
    32'haaaa_aaaa, 32'd7
  };

  sitda_in_if #(.VALUE_WIDTH(VW)) number_ch ();
  sitda_out_if                    text_ch ();

  signed_int_to_decimal_ascii #(.VALUE_WIDTH(VW)) i_dut (
    .clk    (clk),
    .rst    (rst),
    .number (number_ch),
    .text   (text_ch)
  );

  sitda_text_checker #(.VALUE_WIDTH(VW)) i_text_check (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (number_ch.valid),
    .in_ready      (number_ch.ready),
    .in_value      (number_ch.value),
    .out_valid     (text_ch.valid),
    .out_ready     (text_ch.ready),
    .out_character (text_ch.character),
    .out_last      (text_ch.last),
    .out_count     (text_ch.char_count),
    .mismatches    (mismatches),
    .pending       (pending),
    .texts_checked (texts_checked),
    .chars_checked (chars_checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d characters still due", cycle_count, pending);
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [VW-1:0] pick_value();
    logic [VW-1:0] r;
    logic [VW-1:0] p10;
    int            k;
    case ($urandom_range(0, 5))
      0, 1: r = $urandom;
      2: r = $urandom_range(0, 99);
      3: begin
        k   = $urandom_range(0, 9);
        p10 = 1;
        repeat (k) p10 = p10 * 10;
        r   = p10 - $urandom_range(0, 1);
      end
      4: r = $urandom >> $urandom_range(0, 31);
      default: begin
        if ($urandom_range(0, 1)) r = 32'h8000_0000 + $urandom_range(0, 3);
        else r = 32'h7fff_ffff - $urandom_range(0, 3);
      end
    endcase
    if ($urandom_range(0, 1)) r = ~r + 1'b1;
    return r;
  endfunction

  task automatic send_value(input logic [VW-1:0] v);
    number_ch.valid <= 1'b1;
    number_ch.value <= v;
    do @(posedge clk); while (!number_ch.ready);
    numbers_sent++;
  endtask

  task automatic idle_after();
    src_quiet_left--;
    if (src_quiet_left <= 0) begin
      src_quiet      = ($urandom_range(0, 3) == 0);
      src_quiet_left = $urandom_range(10, 40);
    end
    if (!calm && !src_quiet && $urandom_range(0, 3) == 0) begin
      number_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  task automatic drain();
    number_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // output side: random stalls, quiet stretches, one long hold-off
  initial begin
    int quiet_left;
    logic sink_quiet;
    text_ch.ready = 1'b0;
    quiet_left    = 0;
    sink_quiet    = 1'b0;
    wait (!rst);
    forever begin
      if (long_hold_req) begin
        text_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (!calm && !sink_quiet && $urandom_range(0, 5) == 0) begin
        text_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        text_ch.ready <= 1'b1;
        @(posedge clk);
      end
      quiet_left--;
      if (quiet_left <= 0) begin
        sink_quiet = ($urandom_range(0, 3) == 0);
        quiet_left = $urandom_range(20, 80);
      end
    end
  end

  initial begin
    number_ch.valid = 1'b0;
    number_ch.value = '0;
    rst             = 1'b1;
    calm            = 1'b0;
    long_hold_req   = 1'b0;
    src_quiet       = 1'b0;
    src_quiet_left  = 0;
    numbers_sent    = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_values[i]) begin
      send_value(directed_values[i]);
      idle_after();
    end
    drain();

    for (int n = 0; n < RANDOM_ITEMS + CALM_ITEMS; n++) begin
      if (n == 90) long_hold_req = 1'b1;
      if (n == 180) drain();
      if (n == RANDOM_ITEMS) calm = 1'b1;
      send_value(pick_value());
      idle_after();
    end
    drain();

    $display("Sent %0d numbers: extremes, powers of ten and random values of both signs.",
             numbers_sent);
    $display("Checked %0d texts (%0d characters) under random stalls and a long hold-off.",
             texts_checked, chars_checked);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== signed_int_to_decimal_ascii.f =====
src/sitda_pkg.sv
src/sitda_if.sv
src/sitda_front.sv
src/sitda_back.sv
src/signed_int_to_decimal_ascii.sv
tb/sitda_text_checker.sv
tb/signed_int_to_decimal_ascii_tb.sv
